@@ design/msk_pkg.sv @@
`timescale 1ns / 1ps

package msk_pkg;

	localparam int DEFAULT_STACK_DEPTH = 64;
	localparam int DEFAULT_VALUE_WIDTH = 32;

	localparam int STATUS_WIDTH = 2;

	localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW  = 2'd2;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// move applied to every cell of the chain in the same cycle
	typedef struct packed {
		logic push;
		logic pop;
	} msk_shift_t;

endpackage

@@ design/msk_cell.sv @@
`timescale 1ns / 1ps

module msk_cell #(
	parameter int VALUE_WIDTH = msk_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  msk_pkg::msk_shift_t           shift,
	input  logic signed [VALUE_WIDTH-1:0] above_value,
	input  logic signed [VALUE_WIDTH-1:0] above_min,
	input  logic signed [VALUE_WIDTH-1:0] below_value,
	input  logic signed [VALUE_WIDTH-1:0] below_min,
	output logic signed [VALUE_WIDTH-1:0] entry_value,
	output logic signed [VALUE_WIDTH-1:0] entry_min
);
	import msk_pkg::*;

	logic signed [VALUE_WIDTH-1:0] value_q;
	logic signed [VALUE_WIDTH-1:0] min_q;

	// push moves entries away from the top, pop moves them towards it
	always_ff @(posedge clk) begin
		if (shift.push) begin
			value_q <= above_value;
			min_q   <= above_min;
		end else if (shift.pop) begin
			value_q <= below_value;
			min_q   <= below_min;
		end
	end

	assign entry_value = value_q;
	assign entry_min   = min_q;

endmodule

@@ design/msk_ctrl.sv @@
`timescale 1ns / 1ps

module msk_ctrl #(
	parameter int STACK_DEPTH = msk_pkg::DEFAULT_STACK_DEPTH,
	parameter int VALUE_WIDTH = msk_pkg::DEFAULT_VALUE_WIDTH,
	localparam int CountWidth = $clog2(STACK_DEPTH + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic signed [VALUE_WIDTH-1:0]         value,
	input  logic signed [VALUE_WIDTH-1:0]         head_value,
	input  logic signed [VALUE_WIDTH-1:0]         head_min,
	output msk_pkg::msk_shift_t                   shift,
	output logic signed [VALUE_WIDTH-1:0]         push_min,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [msk_pkg::STATUS_WIDTH-1:0]      status,
	output logic [CountWidth-1:0]                 entry_count,
	output logic                                  is_empty,
	output logic signed [VALUE_WIDTH-1:0]         top_value,
	output logic signed [VALUE_WIDTH-1:0]         lowest_value
);
	import msk_pkg::*;

	localparam logic [CountWidth-1:0] FullCount = CountWidth'(STACK_DEPTH);

	logic [CountWidth-1:0]   count_q;
	logic [STATUS_WIDTH-1:0] status_q;
	logic                    out_valid_q;
	logic                    accept;
	logic                    empty;
	logic                    full;
	logic [STATUS_WIDTH-1:0] status_d;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign empty    = (count_q == '0);
	assign full     = (count_q == FullCount);

	assign shift.push = accept && (action == ACT_PUSH) && !full;
	assign shift.pop  = accept && (action == ACT_POP) && !empty;

	// running minimum kept beside the pushed value
	assign push_min = (empty || (value < head_min)) ? value : head_min;

	always_comb begin
		status_d = ST_OK;
		if (action == ACT_PUSH && full)
			status_d = ST_OVERFLOW;
		else if (action == ACT_POP && empty)
			status_d = ST_UNDERFLOW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (shift.push)
				count_q <= count_q + 1'b1;
			else if (shift.pop)
				count_q <= count_q - 1'b1;
			if (accept) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the stack only moves on an accepted beat, which also refreshes the result
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_count  = count_q;
	assign is_empty     = empty;
	assign top_value    = empty ? '0 : head_value;
	assign lowest_value = empty ? '0 : head_min;

endmodule

@@ design/stack_with_running_minimum_top.sv @@
`timescale 1ns / 1ps

// channel  handshake            payload
// in       in_valid, in_ready   action, value
// out      out_valid, out_ready status, entry_count, is_empty, top_value, lowest_value
//
// one beat per cycle unless output stalls it; a push or pop with status ST_OK shifts
// the cell chain one place; the result comes out of the output register next cycle.
// arst_n empties the stack; cell contents are left as they are.
// a new beat is taken whenever the output register is empty or being drained.

module stack_with_running_minimum_top #(
	parameter int STACK_DEPTH = msk_pkg::DEFAULT_STACK_DEPTH,
	parameter int VALUE_WIDTH = msk_pkg::DEFAULT_VALUE_WIDTH,
	localparam int CountWidth = $clog2(STACK_DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic signed [VALUE_WIDTH-1:0]    value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [msk_pkg::STATUS_WIDTH-1:0] status,
	output logic [CountWidth-1:0]            entry_count,
	output logic                             is_empty,
	output logic signed [VALUE_WIDTH-1:0]    top_value,
	output logic signed [VALUE_WIDTH-1:0]    lowest_value
);
	import msk_pkg::*;

	msk_shift_t                    shift;
	logic signed [VALUE_WIDTH-1:0] push_min;
	logic signed [VALUE_WIDTH-1:0] cell_value [STACK_DEPTH];
	logic signed [VALUE_WIDTH-1:0] cell_min   [STACK_DEPTH];

	msk_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.value        (value),
		.head_value   (cell_value[0]),
		.head_min     (cell_min[0]),
		.shift        (shift),
		.push_min     (push_min),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.top_value    (top_value),
		.lowest_value (lowest_value)
	);

	// cell 0 holds the top entry
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] above_value;
		logic signed [VALUE_WIDTH-1:0] above_min;
		logic signed [VALUE_WIDTH-1:0] below_value;
		logic signed [VALUE_WIDTH-1:0] below_min;

		if (i == 0) begin : g_head
			assign above_value = value;
			assign above_min   = push_min;
		end else begin : g_inner
			assign above_value = cell_value[i-1];
			assign above_min   = cell_min[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_tail
			assign below_value = '0;
			assign below_min   = '0;
		end else begin : g_link
			assign below_value = cell_value[i+1];
			assign below_min   = cell_min[i+1];
		end

		msk_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk         (clk),
			.shift       (shift),
			.above_value (above_value),
			.above_min   (above_min),
			.below_value (below_value),
			.below_min   (below_min),
			.entry_value (cell_value[i]),
			.entry_min   (cell_min[i])
		);
	end

endmodule

@@ verif/min_stack_checker.sv @@
`timescale 1ns / 1ps

module min_stack_checker #(
	parameter int DEPTH = 64,
	parameter int VW = 32,
	parameter int CW = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             action,
	input  logic signed [VW-1:0]             value,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [msk_pkg::STATUS_WIDTH-1:0] status,
	input  logic [CW-1:0]                    entry_count,
	input  logic                             is_empty,
	input  logic signed [VW-1:0]             top_value,
	input  logic signed [VW-1:0]             lowest_value,
	output int                               mismatches,
	output int                               outstanding
);
	import msk_pkg::*;

	typedef struct packed {
		logic [STATUS_WIDTH-1:0] status;
		logic [CW-1:0]           count;
		logic                    empty;
		logic signed [VW-1:0]    top;
		logic signed [VW-1:0]    lowest;
	} stack_view_t;

	logic signed [VW-1:0] held_values [DEPTH];
	logic signed [VW-1:0] held_minima [DEPTH];
	int                   fill = 0;
	stack_view_t          awaited_views [$];
	int                   bad_beats = 0;

	function automatic stack_view_t step_min_stack(input logic op,
			input logic signed [VW-1:0] v);
		stack_view_t          view;
		logic signed [VW-1:0] lowest;
		view.status = ST_OK;
		if (op == ACT_PUSH) begin
			if (fill >= DEPTH) begin
				view.status = ST_OVERFLOW;
			end else begin
				lowest = v;
				// a tie keeps the earlier minimum
				if (fill > 0 && !(v < held_minima[fill-1]))
					lowest = held_minima[fill-1];
				held_values[fill] = v;
				held_minima[fill] = lowest;
				fill++;
			end
		end else if (fill == 0) begin
			view.status = ST_UNDERFLOW;
		end else begin
			fill--;
		end
		view.count = CW'(fill);
		view.empty = (fill == 0);
		view.top = (fill > 0) ? held_values[fill-1] : '0;
		view.lowest = (fill > 0) ? held_minima[fill-1] : '0;
		return view;
	endfunction

	always @(posedge clk) begin
		stack_view_t want;
		stack_view_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				awaited_views.push_back(step_min_stack(action, value));
			if (out_valid && out_ready) begin
				got = '{status, entry_count, is_empty, top_value, lowest_value};
				if (awaited_views.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("result beat with nothing expected: status %0d count %0d",
							status, entry_count);
				end else begin
					want = awaited_views.pop_front();
					if (want !== got) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display({"mismatch (exp/got): status %0d/%0d count %0d/%0d ",
								"empty %0b/%0b top %0d/%0d min %0d/%0d"},
								want.status, got.status, want.count, got.count,
								want.empty, got.empty, want.top, got.top,
								want.lowest, got.lowest);
					end
				end
			end
		end
		mismatches <= bad_beats;
		outstanding <= awaited_views.size();
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import msk_pkg::*;

	localparam int DEPTH = 64;
	localparam int VW = 32;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RANDOM_OPS = 1750;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {MIX_PUSH, MIX_POP, MIX_EVEN, MIX_FILL} op_mix_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        action = ACT_PUSH;
	logic signed [VW-1:0]        value = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [STATUS_WIDTH-1:0]     status;
	logic [CW-1:0]               entry_count;
	logic                        is_empty;
	logic signed [VW-1:0]        top_value;
	logic signed [VW-1:0]        lowest_value;

	int mismatches;
	int outstanding;
	int tx_max_gap = 8;
	int rx_max_gap = 8;
	bit hold_output = 1'b0;
	int cycles = 0;

	stack_with_running_minimum_top #(
		.STACK_DEPTH(DEPTH),
		.VALUE_WIDTH(VW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.top_value(top_value),
		.lowest_value(lowest_value)
	);

	min_stack_checker #(
		.DEPTH(DEPTH),
		.VW(VW),
		.CW(CW)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.top_value(top_value),
		.lowest_value(lowest_value),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** stack_with_running_minimum_top: FAILED **");
			$finish;
		end
	end

	task automatic offer_op(input logic op, input logic signed [VW-1:0] v);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= op;
		value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering and wait for every outstanding result beat
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic signed [VW-1:0] random_operand();
		logic signed [VW-1:0] v;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh7fffffff;
					1: v = 32'sh80000000;
					2: v = '0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			// narrow range so that ties with the minimum are common
			1: v = $signed(VW'($urandom_range(0, 16))) - 8;
			4: v = 32'sh7fffffff - $signed(VW'($urandom_range(0, 15)));
			5: v = 32'sh80000000 + $signed(VW'($urandom_range(0, 15)));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// receiver: random stall per beat, plus one long hold-off on request
	initial begin
		while (!arst_n) @(posedge clk);
		forever begin
			int stall;
			stall = $urandom_range(0, rx_max_gap);
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		int      sent;
		int      span;
		int      push_pct;
		op_mix_t mix;
		logic    op;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on an empty stack, the value being ignored
		offer_op(ACT_POP, 32'sh7fffffff);
		offer_op(ACT_POP, 32'sh80000000);
		offer_op(ACT_PUSH, 5);
		offer_op(ACT_PUSH, 5);
		offer_op(ACT_PUSH, 7);
		offer_op(ACT_PUSH, 3);
		offer_op(ACT_PUSH, 3);
		offer_op(ACT_PUSH, 32'sh7fffffff);
		offer_op(ACT_PUSH, 32'sh80000000);
		offer_op(ACT_PUSH, -1);
		offer_op(ACT_PUSH, 0);
		repeat (10) offer_op(ACT_POP, random_operand());
		wait_drained();

		while (sent < RANDOM_OPS) begin
			mix = op_mix_t'($urandom_range(0, 3));
			case (mix)
				MIX_PUSH: push_pct = 80;
				MIX_POP:  push_pct = 20;
				MIX_EVEN: push_pct = 50;
				default:  push_pct = 100;
			endcase
			span = (mix == MIX_FILL) ? DEPTH + $urandom_range(2, 8) : $urandom_range(10, 80);
			tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
			rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
			for (int i = 0; i < span; i++) begin
				op = ($urandom_range(1, 100) <= push_pct) ? ACT_PUSH : ACT_POP;
				offer_op(op, random_operand());
				sent++;
				// output held off while beats keep coming, so the input stalls
				if (sent == 600)
					hold_output = 1'b1;
				if (sent == 1200) begin
					wait_drained();
					repeat (20) @(posedge clk);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("** stack_with_running_minimum_top: PASSED **");
		end else begin
			$display("** stack_with_running_minimum_top: FAILED **");
		end
		$finish;
	end

endmodule

@@ stack_with_running_minimum_top.f @@
design/msk_pkg.sv
design/msk_cell.sv
design/msk_ctrl.sv
design/stack_with_running_minimum_top.sv
verif/min_stack_checker.sv
verif/tb_top.sv
